### src/nat64_ipv6_to_ipv4_header_translate_unit_assert.svh
// ----------------------------------------------------------------------------
// NAT64 translate unit assertion macros
// Shared property forms, clocked on i_clk with reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef NAT64_IPV6_TO_IPV4_HEADER_TRANSLATE_UNIT_ASSERT_SVH
`define NAT64_IPV6_TO_IPV4_HEADER_TRANSLATE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define N64TR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define N64TR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/n64tr_pkg.sv
// ----------------------------------------------------------------------------
// n64tr_pkg
// Types, protocol codes and helper functions for the NAT64 translate unit.
// ----------------------------------------------------------------------------
package n64tr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROUTER_ADDR = 2'd0;
    localparam logic [1:0] CFG_ADDR_VALID  = 2'd1;
    localparam logic [1:0] CFG_PREFIX      = 2'd2;

    localparam logic [31:0] PREFIX_RESET = 32'h0064_FF9B;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;

    // Fixed IPv4 header words
    localparam logic [15:0] IPV4_VER_TOS   = 16'h4500;
    localparam logic [15:0] IPV4_FLAGS_DF  = 16'h4000;
    localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;

    // ICMPv6 types
    localparam logic [7:0] ICMP6_DEST_UNREACH  = 8'd1;
    localparam logic [7:0] ICMP6_PKT_TOO_BIG   = 8'd2;
    localparam logic [7:0] ICMP6_TIME_EXCEEDED = 8'd3;
    localparam logic [7:0] ICMP6_PARAM_PROB    = 8'd4;
    localparam logic [7:0] ICMP6_ECHO_REQ      = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REP      = 8'd129;

    // ICMPv6 destination unreachable codes
    localparam logic [7:0] UNREACH6_NO_ROUTE     = 8'd0;
    localparam logic [7:0] UNREACH6_ADMIN        = 8'd1;
    localparam logic [7:0] UNREACH6_BEYOND_SCOPE = 8'd2;
    localparam logic [7:0] UNREACH6_ADDR         = 8'd3;
    localparam logic [7:0] UNREACH6_PORT         = 8'd4;

    // ICMPv6 parameter problem codes
    localparam logic [7:0] PARAM6_HDR_FIELD = 8'd0;
    localparam logic [7:0] PARAM6_NEXT_HDR  = 8'd1;

    // ICMPv4 types
    localparam logic [7:0] ICMP4_ECHO_REP      = 8'd0;
    localparam logic [7:0] ICMP4_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] ICMP4_ECHO_REQ      = 8'd8;
    localparam logic [7:0] ICMP4_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP4_PARAM_PROB    = 8'd12;

    // ICMPv4 destination unreachable codes
    localparam logic [7:0] UNREACH4_HOST        = 8'd1;
    localparam logic [7:0] UNREACH4_PROTO       = 8'd2;
    localparam logic [7:0] UNREACH4_PORT        = 8'd3;
    localparam logic [7:0] UNREACH4_FRAG_NEEDED = 8'd4;
    localparam logic [7:0] UNREACH4_HOST_ADMIN  = 8'd10;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_XLATE = 2'd1,
        ACT_DROP  = 2'd2
    } t_action;

    // One parsed IPv6 header
    typedef struct packed {
        logic        frame_is_ipv6;
        logic [31:0] dest_top_word;
        logic [31:0] dest_low_word;
        logic [7:0]  next_header;
        logic [7:0]  hops_left;
        logic [15:0] payload_length;
        logic        icmp_present;
        logic [7:0]  icmp6_kind;
        logic [7:0]  icmp6_subcode;
        logic [31:0] icmp6_rest;
    } t_in;

    // Translated header fields, zero unless action is translate
    typedef struct packed {
        t_action     action;
        logic        is_icmp;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [7:0]  ttl;
        logic [15:0] tlen;
        logic [7:0]  t4;
        logic [7:0]  c4;
        logic [31:0] r4;
    } t_hdr;

    // Header plus unfolded checksum sums
    typedef struct packed {
        t_hdr        hdr;
        logic [19:0] hsum;
        logic [17:0] isum;
    } t_sum;

    // Final result
    typedef struct packed {
        t_hdr        hdr;
        logic [15:0] ipv4_csum;
        logic [15:0] icmp_csum;
    } t_result;

    typedef struct packed {
        logic        ok;
        logic [7:0]  t4;
        logic [7:0]  c4;
        logic [31:0] r4;
    } t_icmp_map;

    // ICMPv6 -> ICMPv4 type, code and rest-word mapping; ok low means drop
    function automatic t_icmp_map map_icmp(input logic [7:0] t6, input logic [7:0] c6,
                                           input logic [31:0] r6);
        t_icmp_map   m;
        logic [31:0] mtu;
        logic [7:0]  ptr;
        m   = '0;
        m.ok = 1'b1;
        mtu = r6 - 32'd20;
        ptr = '0;
        case (t6)
            ICMP6_ECHO_REQ: begin
                m.t4 = ICMP4_ECHO_REQ;
                m.r4 = r6;
            end
            ICMP6_ECHO_REP: begin
                m.t4 = ICMP4_ECHO_REP;
                m.r4 = r6;
            end
            ICMP6_DEST_UNREACH: begin
                m.t4 = ICMP4_DEST_UNREACH;
                case (c6)
                    UNREACH6_NO_ROUTE, UNREACH6_BEYOND_SCOPE, UNREACH6_ADDR:
                        m.c4 = UNREACH4_HOST;
                    UNREACH6_ADMIN: m.c4 = UNREACH4_HOST_ADMIN;
                    UNREACH6_PORT:  m.c4 = UNREACH4_PORT;
                    default:        m.ok = 1'b0;
                endcase
            end
            ICMP6_PKT_TOO_BIG: begin
                m.t4 = ICMP4_DEST_UNREACH;
                m.c4 = UNREACH4_FRAG_NEEDED;
                if (mtu[31:16] != 16'd0) begin
                    m.ok = 1'b0;
                end else begin
                    m.r4 = mtu;
                end
            end
            ICMP6_TIME_EXCEEDED: begin
                m.t4 = ICMP4_TIME_EXCEEDED;
                m.c4 = c6;
            end
            ICMP6_PARAM_PROB: begin
                if (c6 == PARAM6_NEXT_HDR) begin
                    m.t4 = ICMP4_DEST_UNREACH;
                    m.c4 = UNREACH4_PROTO;
                end else if (c6 != PARAM6_HDR_FIELD) begin
                    m.ok = 1'b0;
                end else begin
                    m.t4 = ICMP4_PARAM_PROB;
                    // IPv6 header offset -> IPv4 header offset
                    if (r6 <= 32'd1) begin
                        ptr = r6[7:0];
                    end else if (r6 == 32'd4 || r6 == 32'd5) begin
                        ptr = 8'd2;
                    end else if (r6 == 32'd6) begin
                        ptr = 8'd9;
                    end else if (r6 == 32'd7) begin
                        ptr = 8'd8;
                    end else if (r6 >= 32'd8 && r6 <= 32'd23) begin
                        ptr = 8'd12;
                    end else if (r6 >= 32'd24 && r6 <= 32'd39) begin
                        ptr = 8'd16;
                    end else begin
                        m.ok = 1'b0;
                    end
                    m.r4 = {ptr, 24'd0};
                end
            end
            default: m.ok = 1'b0;
        endcase
        return m;
    endfunction

    // Ones-complement fold of a 20-bit sum, inverted
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] a;
        logic [16:0] b;
        a = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        b = {1'b0, a[15:0]} + {16'd0, a[16]};
        return ~b[15:0];
    endfunction

endpackage

### src/n64tr_classify.sv
// ----------------------------------------------------------------------------
// n64tr_classify
// Stage 1: prefix match, pass/drop decision, ICMP mapping, total length.
// ----------------------------------------------------------------------------
module n64tr_classify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_valid,
    input  n64tr_pkg::t_in     i_in,
    input  logic [31:0]        i_router_addr,
    input  logic               i_addr_valid,
    input  logic [31:0]        i_prefix,
    output logic               o_valid,
    output n64tr_pkg::t_hdr    o_hdr
);
    import n64tr_pkg::*;

    logic      r_valid;
    t_hdr      r_hdr;
    t_hdr      n_hdr;
    t_icmp_map w_map;
    logic      w_match;
    logic      w_icmp;

    assign w_map   = map_icmp(i_in.icmp6_kind, i_in.icmp6_subcode, i_in.icmp6_rest);
    assign w_match = i_in.frame_is_ipv6 && (i_in.dest_top_word == i_prefix);
    assign w_icmp  = (i_in.next_header == PROTO_ICMPV6);

    always_comb begin
        n_hdr = '0;
        if (!w_match) begin
            n_hdr.action = ACT_PASS;
        end else if (!i_addr_valid) begin
            n_hdr.action = ACT_DROP;
        end else if (w_icmp && (!i_in.icmp_present || !w_map.ok)) begin
            n_hdr.action = ACT_DROP;
        end else begin
            n_hdr.action  = ACT_XLATE;
            n_hdr.is_icmp = w_icmp;
            n_hdr.src     = i_router_addr;
            n_hdr.dst     = i_in.dest_low_word;
            n_hdr.proto   = w_icmp ? PROTO_ICMP : i_in.next_header;
            n_hdr.ttl     = i_in.hops_left;
            n_hdr.tlen    = i_in.payload_length + IPV4_HDR_BYTES;
            if (w_icmp) begin
                n_hdr.t4 = w_map.t4;
                n_hdr.c4 = w_map.c4;
                n_hdr.r4 = w_map.r4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_valid = r_valid;
    assign o_hdr   = r_hdr;

endmodule

### src/n64tr_csum_sum.sv
// ----------------------------------------------------------------------------
// n64tr_csum_sum
// Stage 2: wide adds of the IPv4 and ICMPv4 header words.
// ----------------------------------------------------------------------------
module n64tr_csum_sum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_valid,
    input  n64tr_pkg::t_hdr    i_hdr,
    output logic               o_valid,
    output n64tr_pkg::t_sum    o_sum
);
    import n64tr_pkg::*;

    logic        r_valid;
    t_sum        r_sum;
    logic [19:0] w_hsum;
    logic [17:0] w_isum;

    assign w_hsum = {4'd0, IPV4_VER_TOS} + {4'd0, i_hdr.tlen} + {4'd0, IPV4_FLAGS_DF}
                  + {4'd0, i_hdr.ttl, 8'd0} + {12'd0, i_hdr.proto}
                  + {4'd0, i_hdr.src[31:16]} + {4'd0, i_hdr.src[15:0]}
                  + {4'd0, i_hdr.dst[31:16]} + {4'd0, i_hdr.dst[15:0]};

    assign w_isum = {2'd0, i_hdr.t4, i_hdr.c4}
                  + {2'd0, i_hdr.r4[31:16]} + {2'd0, i_hdr.r4[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum.hdr  <= i_hdr;
            r_sum.hsum <= w_hsum;
            r_sum.isum <= w_isum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

### src/n64tr_csum_fold.sv
// ----------------------------------------------------------------------------
// n64tr_csum_fold
// Stage 3: carry fold and inversion of both checksums; output register.
// ----------------------------------------------------------------------------
module n64tr_csum_fold (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_valid,
    input  n64tr_pkg::t_sum     i_sum,
    output logic                o_valid,
    output n64tr_pkg::t_result  o_result
);
    import n64tr_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    w_xlate;

    assign w_xlate = (i_sum.hdr.action == ACT_XLATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result.hdr       <= i_sum.hdr;
            r_result.ipv4_csum <= w_xlate ? fold16(i_sum.hsum) : 16'd0;
            r_result.icmp_csum <= (w_xlate && i_sum.hdr.is_icmp)
                                  ? fold16({2'd0, i_sum.isum}) : 16'd0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### src/nat64_ipv6_to_ipv4_header_translate_unit.sv
// ----------------------------------------------------------------------------
// nat64_ipv6_to_ipv4_header_translate_unit
// Stateless IPv6 -> IPv4 header translator for a NAT64 edge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries the parsed fields of one IPv6
//   packet; a transfer happens when i_valid is high and o_stall is low.
//   Output channel (o_valid / i_stall) carries one result per input: pass,
//   drop, or a translated IPv4 header with ICMPv4 fields and checksums.
//   Three register stages (classify, checksum sum, checksum fold). Throughput
//   is one transfer per cycle while i_stall does not hold the output. A stalled
//   result holds in the output register; each stage keeps loading while the
//   stage after it is empty, so bubbles close up before o_stall rises.
//   o_stall rises only when all three stages hold items. The user must write
//   the configuration port (i_cfg_we / i_cfg_index / i_cfg_wdata) only while
//   the pipeline is empty; the block does not enforce this. Reset clears all
//   valid bits, sets the router address to 0 (unset) and the prefix to 64:ff9b.
// ----------------------------------------------------------------------------
`include "nat64_ipv6_to_ipv4_header_translate_unit_assert.svh"

module nat64_ipv6_to_ipv4_header_translate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_frame_is_ipv6,
    input  logic [31:0] i_dest_top_word,
    input  logic [31:0] i_dest_low_word,
    input  logic [7:0]  i_next_header,
    input  logic [7:0]  i_hops_left,
    input  logic [15:0] i_payload_length,
    input  logic        i_icmp_present,
    input  logic [7:0]  i_icmp6_kind,
    input  logic [7:0]  i_icmp6_subcode,
    input  logic [31:0] i_icmp6_rest,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [31:0] o_ipv4_source,
    output logic [31:0] o_ipv4_dest,
    output logic [7:0]  o_ipv4_protocol,
    output logic [7:0]  o_ipv4_ttl,
    output logic [15:0] o_ipv4_total_length,
    output logic [15:0] o_ipv4_checksum,
    output logic [7:0]  o_icmp4_type,
    output logic [7:0]  o_icmp4_code,
    output logic [31:0] o_icmp4_rest,
    output logic [15:0] o_icmp4_checksum
);
    import n64tr_pkg::*;

    // Configuration registers
    logic [31:0] r_router_addr;
    logic        r_addr_valid;
    logic [31:0] r_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_addr <= '0;
            r_addr_valid  <= 1'b0;
            r_prefix      <= PREFIX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROUTER_ADDR: r_router_addr <= i_cfg_wdata;
                CFG_ADDR_VALID:  r_addr_valid  <= i_cfg_wdata[0];
                CFG_PREFIX:      r_prefix      <= i_cfg_wdata;
                default:         ;  // unmapped index, write ignored
            endcase
        end
    end

    // Input payload bundle
    t_in w_in;

    assign w_in.frame_is_ipv6  = i_frame_is_ipv6;
    assign w_in.dest_top_word  = i_dest_top_word;
    assign w_in.dest_low_word  = i_dest_low_word;
    assign w_in.next_header    = i_next_header;
    assign w_in.hops_left      = i_hops_left;
    assign w_in.payload_length = i_payload_length;
    assign w_in.icmp_present   = i_icmp_present;
    assign w_in.icmp6_kind     = i_icmp6_kind;
    assign w_in.icmp6_subcode  = i_icmp6_subcode;
    assign w_in.icmp6_rest     = i_icmp6_rest;

    // Stage load enables: a stage loads when it is empty or its contents
    // move on in the same cycle.
    logic    w_v1;
    logic    w_v2;
    logic    w_v3;
    logic    w_ld1;
    logic    w_ld2;
    logic    w_ld3;
    t_hdr    w_hdr1;
    t_sum    w_sum2;
    t_result w_res3;

    assign w_ld3   = !w_v3 || !i_stall;
    assign w_ld2   = !w_v2 || w_ld3;
    assign w_ld1   = !w_v1 || w_ld2;
    assign o_stall = !w_ld1;

    n64tr_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_ld1),
        .i_valid       (i_valid),
        .i_in          (w_in),
        .i_router_addr (r_router_addr),
        .i_addr_valid  (r_addr_valid),
        .i_prefix      (r_prefix),
        .o_valid       (w_v1),
        .o_hdr         (w_hdr1)
    );

    n64tr_csum_sum u_csum_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ld2),
        .i_valid (w_v1),
        .i_hdr   (w_hdr1),
        .o_valid (w_v2),
        .o_sum   (w_sum2)
    );

    n64tr_csum_fold u_csum_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_ld3),
        .i_valid  (w_v2),
        .i_sum    (w_sum2),
        .o_valid  (w_v3),
        .o_result (w_res3)
    );

    // Result ports
    assign o_valid             = w_v3;
    assign o_action            = w_res3.hdr.action;
    assign o_ipv4_source       = w_res3.hdr.src;
    assign o_ipv4_dest         = w_res3.hdr.dst;
    assign o_ipv4_protocol     = w_res3.hdr.proto;
    assign o_ipv4_ttl          = w_res3.hdr.ttl;
    assign o_ipv4_total_length = w_res3.hdr.tlen;
    assign o_ipv4_checksum     = w_res3.ipv4_csum;
    assign o_icmp4_type        = w_res3.hdr.t4;
    assign o_icmp4_code        = w_res3.hdr.c4;
    assign o_icmp4_rest        = w_res3.hdr.r4;
    assign o_icmp4_checksum    = w_res3.icmp_csum;

    // Assertions
    `N64TR_ASSERT_NEXT(a_in_xfer_lands, i_valid && !o_stall, w_v1,
        "accepted transfer did not reach stage 1")
    `N64TR_ASSERT_SAME(a_stall_only_full, o_stall, w_v1 && w_v2 && w_v3,
        "input stalled with a free pipeline stage")
    `N64TR_ASSERT_SAME(a_nonxlate_zero,
        o_valid && (o_action != ACT_XLATE),
        (o_ipv4_checksum == 16'd0) && (o_icmp4_checksum == 16'd0)
            && (o_ipv4_source == 32'd0) && (o_icmp4_rest == 32'd0),
        "pass or drop result carries nonzero fields")
    `N64TR_ASSERT_SAME(a_icmp_csum_only_icmp,
        o_valid && (o_action == ACT_XLATE) && (o_ipv4_protocol != PROTO_ICMP),
        o_icmp4_checksum == 16'd0,
        "ICMP checksum set on a non-ICMP translation")

endmodule

### dv/nat64_ipv6_to_ipv4_header_translate_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat64_ipv6_to_ipv4_header_translate_unit_tb
// Self-checking bench for the NAT64 translate unit. A directed table covers
// the pass/drop rules, field extremes and every ICMPv6 mapping. Six random
// phases follow, each under its own register setting. Every accepted header
// outside the rows with a known result is run through a local translator, and
// each result transfer is compared field by field in arrival order. Both
// channels idle at random, and there is one long receiver hold to back the pipeline up.
// ----------------------------------------------------------------------------
module nat64_ipv6_to_ipv4_header_translate_unit_tb;

    import n64tr_pkg::*;

    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 300;
    localparam int          PRE_CFG_ROWS = 3;     // table rows run before the router is set
    localparam int          DRAIN_WAIT  = 6;      // 3-stage pipe plus margin
    localparam logic [31:0] PFX         = PREFIX_RESET;

    // Expected output of one transfer, in output port order
    typedef struct packed {
        t_action     action;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [7:0]  ttl;
        logic [15:0] tlen;
        logic [15:0] hcsum;
        logic [7:0]  t4;
        logic [7:0]  c4;
        logic [31:0] r4;
        logic [15:0] icsum;
    } t_v4_hdr;

    // Directed row: when known is set, the result is known_act with all else 0
    typedef struct packed {
        logic    known;
        t_action known_act;
        t_in     pkt;
    } t_dir_row;

    // ------------------------------------------------------------------
    // Clock, reset and DUT inputs; every input is known from time 0
    // ------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = CFG_ROUTER_ADDR;
    logic [31:0] i_cfg_wdata      = '0;
    logic        i_valid          = 1'b0;
    logic        i_frame_is_ipv6  = 1'b0;
    logic [31:0] i_dest_top_word  = '0;
    logic [31:0] i_dest_low_word  = '0;
    logic [7:0]  i_next_header    = '0;
    logic [7:0]  i_hops_left      = '0;
    logic [15:0] i_payload_length = '0;
    logic        i_icmp_present   = 1'b0;
    logic [7:0]  i_icmp6_kind     = '0;
    logic [7:0]  i_icmp6_subcode  = '0;
    logic [31:0] i_icmp6_rest     = '0;
    logic        i_stall          = 1'b1;

    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_action;
    logic [31:0] o_ipv4_source;
    logic [31:0] o_ipv4_dest;
    logic [7:0]  o_ipv4_protocol;
    logic [7:0]  o_ipv4_ttl;
    logic [15:0] o_ipv4_total_length;
    logic [15:0] o_ipv4_checksum;
    logic [7:0]  o_icmp4_type;
    logic [7:0]  o_icmp4_code;
    logic [31:0] o_icmp4_rest;
    logic [15:0] o_icmp4_checksum;

    // Local copy of the register file
    logic [31:0] rtr_addr    = '0;
    logic        rtr_addr_ok = 1'b0;
    logic [31:0] xlat_prefix = PREFIX_RESET;

    t_v4_hdr pending_hdrs[$];       // expected results, oldest first
    int      mismatch_cnt  = 0;
    bit      src_no_gaps   = 1'b0;  // sender offers back to back
    bit      sink_no_stall = 1'b0;  // receiver never stalls
    int      sink_hold_req = 0;     // one-shot long stall, in cycles

    // ------------------------------------------------------------------
    // Directed table. The first rows run right after reset with the router
    // address unset; the rest run after it is programmed.
    // ------------------------------------------------------------------
    t_dir_row dir_rows [26] = '{
        // not IPv6: pass
        '{1'b1, ACT_PASS, '{1'b0, PFX, 32'h0A00_0001, PROTO_ICMPV6, 8'd64, 16'd8,
                            1'b1, ICMP6_ECHO_REQ, 8'd0, 32'd1}},
        // prefix mismatch: pass
        '{1'b1, ACT_PASS, '{1'b1, ~PFX, 32'h0A00_0001, 8'd17, 8'd64, 16'd8,
                            1'b0, 8'd0, 8'd0, 32'd0}},
        // prefix hit but router address unset: drop
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'hC0A8_0101, 8'd17, 8'd64, 16'd100,
                            1'b0, 8'd0, 8'd0, 32'd0}},
        // non-ICMP, all-ones extremes; total length wraps
        '{1'b0, ACT_PASS, '{1'b1, PFX, '1, 8'd6, '1, '1,
                            1'b0, 8'd0, 8'd0, 32'd0}},
        // non-ICMP, all-zero extremes; ICMP fields must be ignored
        '{1'b0, ACT_PASS, '{1'b1, PFX, '0, 8'd0, 8'd0, 16'd0,
                            1'b1, '1, '1, '1}},
        // ICMPv6 header cut off: drop
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h0808_0808, PROTO_ICMPV6, 8'd64, 16'd64,
                            1'b0, ICMP6_ECHO_REQ, 8'd0, 32'd0}},
        // echo: id and sequence carried
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h0808_0808, PROTO_ICMPV6, 8'd64, 16'd64,
                            1'b1, ICMP6_ECHO_REQ, 8'd0, '1}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h0808_0404, PROTO_ICMPV6, 8'd1, 16'd64,
                            1'b1, ICMP6_ECHO_REP, 8'd0, 32'd0}},
        // destination unreachable, every code
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, UNREACH6_NO_ROUTE, 32'hDEAD_BEEF}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, UNREACH6_ADMIN, 32'd0}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, UNREACH6_BEYOND_SCOPE, 32'd0}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, UNREACH6_ADDR, 32'd0}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, UNREACH6_PORT, 32'd0}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'hC633_6407, PROTO_ICMPV6, 8'd60, 16'd1280,
                            1'b1, ICMP6_DEST_UNREACH, 8'd5, 32'd0}},
        // packet too big: MTU window edges
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h0102_0304, PROTO_ICMPV6, 8'd255, 16'd1240,
                            1'b1, ICMP6_PKT_TOO_BIG, 8'd0, 32'd20}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h0102_0304, PROTO_ICMPV6, 8'd255, 16'd1240,
                            1'b1, ICMP6_PKT_TOO_BIG, 8'd0, 32'h0001_0013}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h0102_0304, PROTO_ICMPV6, 8'd255, 16'd1240,
                            1'b1, ICMP6_PKT_TOO_BIG, 8'd0, 32'd19}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h0102_0304, PROTO_ICMPV6, 8'd255, 16'd1240,
                            1'b1, ICMP6_PKT_TOO_BIG, 8'd0, 32'h0001_0014}},
        // time exceeded: code copied as is
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h7F00_0001, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_TIME_EXCEEDED, 8'hFF, '1}},
        // parameter problem, header field: pointer mapping and holes
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h7F00_0002, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, PARAM6_HDR_FIELD, 32'd6}},
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h7F00_0002, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, PARAM6_HDR_FIELD, 32'd39}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h7F00_0002, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, PARAM6_HDR_FIELD, 32'd40}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h7F00_0002, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, PARAM6_HDR_FIELD, 32'd2}},
        // parameter problem, next header: becomes protocol unreachable
        '{1'b0, ACT_PASS, '{1'b1, PFX, 32'h7F00_0003, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, PARAM6_NEXT_HDR, 32'd40}},
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h7F00_0003, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, ICMP6_PARAM_PROB, 8'd2, 32'd0}},
        // unknown ICMPv6 type: drop
        '{1'b1, ACT_DROP, '{1'b1, PFX, 32'h7F00_0004, PROTO_ICMPV6, 8'd2, 16'd48,
                            1'b1, 8'hFF, 8'd0, 32'd0}}
    };

    nat64_ipv6_to_ipv4_header_translate_unit i_dut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Header translator
    // ------------------------------------------------------------------

    // Inverted ones-complement sum folded to 16 bits
    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
        t = t + {16'd0, t[31:16]};
        return ~t[15:0];
    endfunction

    function automatic t_v4_hdr translate_hdr(input t_in p);
        t_v4_hdr     h;
        logic        keep;
        logic [31:0] mtu;
        logic [31:0] sum;
        logic [7:0]  ptr;
        logic [31:0] r6;
        h    = '0;
        keep = 1'b1;
        ptr  = '0;
        r6   = p.icmp6_rest;
        if (!p.frame_is_ipv6 || p.dest_top_word != xlat_prefix)
            return h;
        h.action = ACT_DROP;
        if (!rtr_addr_ok)
            return h;

        if (p.next_header == PROTO_ICMPV6) begin
            if (!p.icmp_present)
                return h;
            case (p.icmp6_kind)
                ICMP6_ECHO_REQ: begin
                    h.t4 = ICMP4_ECHO_REQ;
                    h.r4 = r6;
                end
                ICMP6_ECHO_REP: begin
                    h.t4 = ICMP4_ECHO_REP;
                    h.r4 = r6;
                end
                ICMP6_DEST_UNREACH: begin
                    h.t4 = ICMP4_DEST_UNREACH;
                    case (p.icmp6_subcode)
                        UNREACH6_NO_ROUTE, UNREACH6_BEYOND_SCOPE, UNREACH6_ADDR:
                            h.c4 = UNREACH4_HOST;
                        UNREACH6_ADMIN: h.c4 = UNREACH4_HOST_ADMIN;
                        UNREACH6_PORT:  h.c4 = UNREACH4_PORT;
                        default:        keep = 1'b0;
                    endcase
                end
                ICMP6_PKT_TOO_BIG: begin
                    h.t4 = ICMP4_DEST_UNREACH;
                    h.c4 = UNREACH4_FRAG_NEEDED;
                    mtu  = r6 - 32'd20;        // wraps below 20, then drops
                    if (mtu > 32'h0000_FFFF)
                        keep = 1'b0;
                    else
                        h.r4 = mtu;
                end
                ICMP6_TIME_EXCEEDED: begin
                    h.t4 = ICMP4_TIME_EXCEEDED;
                    h.c4 = p.icmp6_subcode;
                end
                ICMP6_PARAM_PROB: begin
                    if (p.icmp6_subcode == PARAM6_NEXT_HDR) begin
                        h.t4 = ICMP4_DEST_UNREACH;
                        h.c4 = UNREACH4_PROTO;
                    end else if (p.icmp6_subcode != PARAM6_HDR_FIELD) begin
                        keep = 1'b0;
                    end else begin
                        h.t4 = ICMP4_PARAM_PROB;
                        // IPv6 header byte offset -> IPv4 header byte offset
                        if (r6 <= 32'd1)
                            ptr = r6[7:0];
                        else if (r6 == 32'd4 || r6 == 32'd5)
                            ptr = 8'd2;
                        else if (r6 == 32'd6)
                            ptr = 8'd9;
                        else if (r6 == 32'd7)
                            ptr = 8'd8;
                        else if (r6 >= 32'd8 && r6 <= 32'd23)
                            ptr = 8'd12;
                        else if (r6 >= 32'd24 && r6 <= 32'd39)
                            ptr = 8'd16;
                        else
                            keep = 1'b0;
                        h.r4 = {ptr, 24'd0};
                    end
                end
                default: keep = 1'b0;
            endcase
            if (!keep) begin
                h        = '0;
                h.action = ACT_DROP;
                return h;
            end
            sum = {16'd0, h.t4, h.c4} + {16'd0, h.r4[31:16]} + {16'd0, h.r4[15:0]};
            h.icsum = ones_fold(sum);
            h.proto = PROTO_ICMP;
        end else begin
            h.proto = p.next_header;
        end

        h.action = ACT_XLATE;
        h.src    = rtr_addr;
        h.dst    = p.dest_low_word;
        h.ttl    = p.hops_left;
        h.tlen   = p.payload_length + IPV4_HDR_BYTES;
        // id and checksum words are zero and drop out of the sum
        sum = {16'd0, IPV4_VER_TOS} + {16'd0, h.tlen} + {16'd0, IPV4_FLAGS_DF}
            + {16'd0, h.ttl, h.proto}
            + {16'd0, h.src[31:16]} + {16'd0, h.src[15:0]}
            + {16'd0, h.dst[31:16]} + {16'd0, h.dst[15:0]};
        h.hcsum = ones_fold(sum);
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Random headers: mostly prefix hits carrying well-formed ICMPv6, the
    // rest misses, foreign protocols and truncated ICMP.
    // ------------------------------------------------------------------
    function automatic t_in rand_pkt();
        t_in p;
        int  pick;
        p.frame_is_ipv6  = 1'b1;
        p.dest_top_word  = xlat_prefix;
        p.dest_low_word  = $urandom;
        p.next_header    = PROTO_ICMPV6;
        p.hops_left      = 8'($urandom);
        p.payload_length = 16'($urandom);
        p.icmp_present   = 1'b1;
        p.icmp6_subcode  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 5));
        p.icmp6_rest     = $urandom;
        case ($urandom_range(0, 7))
            0: p.icmp6_kind = ICMP6_ECHO_REQ;
            1: p.icmp6_kind = ICMP6_ECHO_REP;
            2: p.icmp6_kind = ICMP6_DEST_UNREACH;
            3: begin
                p.icmp6_kind = ICMP6_PKT_TOO_BIG;
                // mostly legal, some just outside either end of the window
                case ($urandom_range(0, 3))
                    0:       p.icmp6_rest = $urandom_range(0, 40);
                    1:       p.icmp6_rest = $urandom_range(32'h0001_0000, 32'h0001_0030);
                    default: p.icmp6_rest = $urandom_range(20, 32'h0001_0013);
                endcase
            end
            4: p.icmp6_kind = ICMP6_TIME_EXCEEDED;
            5, 6: begin
                p.icmp6_kind = ICMP6_PARAM_PROB;
                if ($urandom_range(0, 3) != 0)
                    p.icmp6_subcode = 8'($urandom_range(0, 1));
                if ($urandom_range(0, 3) != 0)
                    p.icmp6_rest = $urandom_range(0, 45);
            end
            default: p.icmp6_kind = 8'($urandom);
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 5)
            p.frame_is_ipv6 = 1'b0;
        else if (pick < 9)
            p.dest_top_word = $urandom;
        else if (pick < 13)
            p.dest_top_word = xlat_prefix ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 28)
            p.next_header = 8'($urandom);
        else if (pick < 32)
            p.icmp_present = 1'b0;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; printing is capped, counting is not
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < 100)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one header; queue its expected result once the transfer happens.
    // Valid is left high on return so a back-to-back header needs no toggle.
    task automatic send_hdr(input t_in pkt, input logic known, input t_action known_act);
        int      gap;
        t_v4_hdr want;
        gap = src_no_gaps ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {i_frame_is_ipv6, i_dest_top_word, i_dest_low_word, i_next_header, i_hops_left,
         i_payload_length, i_icmp_present, i_icmp6_kind, i_icmp6_subcode,
         i_icmp6_rest} <= pkt;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (known) begin
            want        = '0;
            want.action = known_act;
        end else begin
            want = translate_hdr(pkt);
        end
        pending_hdrs.push_back(want);
    endtask

    // Stop offering and let every queued result come out, then the pipe settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_hdrs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Program all three registers back to back on an idle pipe
    task automatic load_regs(input logic [31:0] addr, input logic addr_ok,
                             input logic [31:0] prefix);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROUTER_ADDR;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        // only bit 0 is kept; upper bits are junk on purpose
        i_cfg_index <= CFG_ADDR_VALID;
        i_cfg_wdata <= {31'($urandom), addr_ok};
        @(posedge i_clk);
        i_cfg_index <= CFG_PREFIX;
        i_cfg_wdata <= prefix;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rtr_addr    = addr;
        rtr_addr_ok = addr_ok;
        xlat_prefix = prefix;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall per result, plus one requested long hold
    // ------------------------------------------------------------------
    initial begin : sink
        int hold;
        @(posedge i_clk);
        forever begin
            if (sink_hold_req != 0) begin
                hold          = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                hold = sink_no_stall ? 0 : $urandom_range(0, 17);
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_v4_hdr want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hdrs.size() == 0) begin
                report_mismatch("unexpected result, action", 32'(o_action), '0);
            end else begin
                want = pending_hdrs.pop_front();
                if (o_action != want.action)
                    report_mismatch("action", 32'(o_action), 32'(want.action));
                if (o_ipv4_source != want.src)
                    report_mismatch("ipv4_source", o_ipv4_source, want.src);
                if (o_ipv4_dest != want.dst)
                    report_mismatch("ipv4_dest", o_ipv4_dest, want.dst);
                if (o_ipv4_protocol != want.proto)
                    report_mismatch("ipv4_protocol", 32'(o_ipv4_protocol), 32'(want.proto));
                if (o_ipv4_ttl != want.ttl)
                    report_mismatch("ipv4_ttl", 32'(o_ipv4_ttl), 32'(want.ttl));
                if (o_ipv4_total_length != want.tlen)
                    report_mismatch("ipv4_total_length", 32'(o_ipv4_total_length),
                                    32'(want.tlen));
                if (o_ipv4_checksum != want.hcsum)
                    report_mismatch("ipv4_checksum", 32'(o_ipv4_checksum), 32'(want.hcsum));
                if (o_icmp4_type != want.t4)
                    report_mismatch("icmp4_type", 32'(o_icmp4_type), 32'(want.t4));
                if (o_icmp4_code != want.c4)
                    report_mismatch("icmp4_code", 32'(o_icmp4_code), 32'(want.c4));
                if (o_icmp4_rest != want.r4)
                    report_mismatch("icmp4_rest", o_icmp4_rest, want.r4);
                if (o_icmp4_checksum != want.icsum)
                    report_mismatch("icmp4_checksum", 32'(o_icmp4_checksum), 32'(want.icsum));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stim
        int i;
        int ph;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset defaults: router address unset, default prefix
        for (i = 0; i < PRE_CFG_ROWS; i++)
            send_hdr(dir_rows[i].pkt, dir_rows[i].known, dir_rows[i].known_act);

        load_regs('1, 1'b1, PREFIX_RESET);
        for (i = PRE_CFG_ROWS; i < $size(dir_rows); i++)
            send_hdr(dir_rows[i].pkt, dir_rows[i].known, dir_rows[i].known_act);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       load_regs('0, 1'b1, PREFIX_RESET);
                1:       load_regs('1, 1'b1, '0);
                2:       load_regs($urandom, 1'b0, $urandom);   // every hit drops
                3:       load_regs($urandom, 1'b1, '1);
                4:       load_regs($urandom, 1'b1, $urandom);
                default: load_regs($urandom, 1'b1, PREFIX_RESET);
            endcase
            // back-to-back offers in phase 1 (with the long hold) and phase 5
            src_no_gaps   = (ph == 1 || ph == 5);
            sink_no_stall = (ph == 5);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the output long enough that all stages fill and o_stall rises
                if (ph == 1 && k == 100)
                    sink_hold_req = 64;
                // sender pauses until the pipe has emptied
                if (ph == 4 && k == 150)
                    wait_drained();
                send_hdr(rand_pkt(), 1'b0, ACT_PASS);
            end
        end

        wait_drained();
        if (mismatch_cnt == 0 && pending_hdrs.size() == 0) begin
            $display("nat64_ipv6_to_ipv4_header_translate_unit_tb: clean");
        end else begin
            $display("nat64_ipv6_to_ipv4_header_translate_unit_tb: errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("nat64_ipv6_to_ipv4_header_translate_unit_tb: errors");
        $finish;
    end

endmodule
